### sv/apd_pkg.sv
package apd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 12;
    localparam int GAIN_W     = 15;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Delay line: depth is a power of two so the pointer wraps on its own
    localparam int ADDR_W     = 12;
    localparam int LINE_DEPTH = 1 << ADDR_W;

    // Datapath widths
    localparam int MUL_A_W = 32;                 // vq, Q.15
    localparam int MUL_B_W = GAIN_W + 1;         // gain with a zero sign bit
    localparam int PROD_W  = MUL_A_W + MUL_B_W;  // g*d or g*vq
    localparam int YQ_W    = PROD_W + 1;         // d*2^30 - g*vq, Q.30
    localparam int NARROW_W = 19;                // truncated values before clamping

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_SAMPLES = 4'd0,
        REG_FEEDBACK_GAIN = 4'd1
    } apd_reg_t;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd1000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd4293;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_SUM,
        ST_MUL_V,
        ST_OUT
    } apd_state_t;

endpackage

### sv/apd_if.sv
// Input item channel
interface apd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [apd_pkg::SAMPLE_W-1:0]   sample_in;
    logic                                  end_of_block;

    modport source (output valid, output sample_in, output end_of_block, input ready);
    modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

// Result item channel
interface apd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [apd_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  block_done;

    modport source (output valid, output sample_out, output block_done, input ready);
    modport sink   (input valid, input sample_out, input block_done, output ready);
endinterface

// Configuration write channel
interface apd_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [apd_pkg::CFG_IDX_W-1:0]         index;
    logic [apd_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/allpass_delay_filter.sv
// Schroeder all-pass stage for signed 16-bit audio. Each sample reads the delay
// line entry delay_samples behind the write pointer (d), forms v = x + g*d and
// y = d - g*v with g = feedback_gain/32768, stores v (truncated toward zero,
// clamped to 16 bits) and returns y (same rounding and clamping). For each
// sample the accept cycle issues the delay line read, then two passes
// through a single shared 16x32 multiplier with an add between them, then the
// result is loaded into the output register. in_ch.ready is low while a sample
// is in flight; a finished result may wait in the output register while the
// next sample is accepted. The delay line is a single-port-write, registered-
// read RAM of 4096 x 16. It has no clearing pass: a wrap flag and the write
// pointer track which entries were written since reset, and unwritten entries
// read as zero, so the block is ready right after reset. Configuration writes
// are taken in any cycle and should be made while the block is idle.
module allpass_delay_filter (
    input  logic      clk,
    input  logic      rst_n,
    apd_in_if.sink    in_ch,
    apd_out_if.source out_ch,
    apd_cfg_if.sink   cfg
);

    typedef struct packed {
        logic in_ready;
        logic ram_re;
        logic ld_d;       // first multiply: g*d
        logic ld_vq;      // vq = x*2^15 + g*d
        logic ld_gv;      // second multiply: g*vq, write v
        logic ld_out;     // load output register, advance pointer
    } apd_ctrl_t;

    // Clamp a truncated value to the 16-bit range
    function automatic logic signed [apd_pkg::SAMPLE_W-1:0] sat16(
        input logic signed [apd_pkg::NARROW_W-1:0] v
    );
        logic signed [apd_pkg::SAMPLE_W-1:0] r;
        if (v > $signed(19'sd32767))
        begin
            r = 16'sh7FFF;
        end
        else if (v < -$signed(19'sd32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[apd_pkg::SAMPLE_W-1:0];
        end
        return r;
    endfunction

    apd_pkg::apd_state_t state_reg, state_next;
    apd_ctrl_t           ctrl;

    logic [apd_pkg::DELAY_W-1:0] delay_reg;
    logic [apd_pkg::GAIN_W-1:0]  gain_reg;
    logic [apd_pkg::ADDR_W-1:0]  wp_reg;
    logic                        wrapped_reg;
    logic                        rd_valid_reg;
    logic                        out_valid_reg;

    logic signed [apd_pkg::SAMPLE_W-1:0] x_reg;
    logic                                eob_reg;
    logic signed [apd_pkg::SAMPLE_W-1:0] d_reg;
    logic signed [apd_pkg::PROD_W-1:0]   prod_reg;
    logic signed [apd_pkg::MUL_A_W-1:0]  vq_reg;
    logic signed [apd_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                out_done_reg;

    logic                                in_accept;
    logic                                out_free;
    logic [apd_pkg::ADDR_W-1:0]          rd_addr;
    logic                                rd_valid;
    logic [apd_pkg::SAMPLE_W-1:0]        ram_rdata;
    logic signed [apd_pkg::SAMPLE_W-1:0] d_val;
    logic signed [apd_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [apd_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [apd_pkg::PROD_W-1:0]   mul_p;
    logic signed [apd_pkg::MUL_A_W-1:0]  vq_sum;
    logic signed [apd_pkg::MUL_A_W-1:0]  vq_adj;
    logic signed [apd_pkg::MUL_A_W-1:0]  vq_shift;
    logic signed [apd_pkg::SAMPLE_W-1:0] v_sat;
    logic signed [apd_pkg::YQ_W-1:0]     yq;
    logic signed [apd_pkg::YQ_W-1:0]     yq_adj;
    logic signed [apd_pkg::YQ_W-1:0]     yq_shift;
    logic signed [apd_pkg::SAMPLE_W-1:0] y_sat;

    assign in_accept = in_ch.valid && ctrl.in_ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign cfg.ready = 1'b1;

    // Tap address and whether that entry was written since reset
    assign rd_addr  = wp_reg - delay_reg[apd_pkg::ADDR_W-1:0];
    assign rd_valid = wrapped_reg || (rd_addr < wp_reg);

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apd_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = apd_pkg::ST_MUL_D;
                end
            end
            apd_pkg::ST_MUL_D: state_next = apd_pkg::ST_SUM;
            apd_pkg::ST_SUM:   state_next = apd_pkg::ST_MUL_V;
            apd_pkg::ST_MUL_V: state_next = apd_pkg::ST_OUT;
            apd_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = apd_pkg::ST_IDLE;
                end
            end
            default: state_next = apd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: control outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            apd_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.ram_re   = in_ch.valid;
            end
            apd_pkg::ST_MUL_D: ctrl.ld_d   = 1'b1;
            apd_pkg::ST_SUM:   ctrl.ld_vq  = 1'b1;
            apd_pkg::ST_MUL_V: ctrl.ld_gv  = 1'b1;
            apd_pkg::ST_OUT:   ctrl.ld_out = out_free;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= apd_pkg::DELAY_RESET;
            gain_reg  <= apd_pkg::GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                apd_pkg::REG_DELAY_SAMPLES: delay_reg <= cfg.data[apd_pkg::DELAY_W-1:0];
                apd_pkg::REG_FEEDBACK_GAIN: gain_reg  <= cfg.data[apd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Write pointer, fill tracking and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                rd_valid_reg <= rd_valid;
            end
            if (ctrl.ld_out)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (&wp_reg)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (ctrl.ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Delay line
    apd_ram #(
        .WIDTH (apd_pkg::SAMPLE_W),
        .DEPTH (apd_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ctrl.ld_gv),
        .waddr (wp_reg),
        .wdata (v_sat),
        .re    (ctrl.ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Entries not yet written read as zero
    assign d_val = rd_valid_reg ? $signed(ram_rdata) : '0;

    // Shared multiplier: gain times d, then gain times vq
    assign mul_a = ctrl.ld_gv ? vq_reg
                              : {{(apd_pkg::MUL_A_W-apd_pkg::SAMPLE_W){d_val[apd_pkg::SAMPLE_W-1]}},
                                 d_val};
    assign mul_b = $signed({1'b0, gain_reg});
    assign mul_p = mul_a * mul_b;

    // vq = x*2^15 + g*d
    assign vq_sum = {{(apd_pkg::MUL_A_W-apd_pkg::SAMPLE_W-15){x_reg[apd_pkg::SAMPLE_W-1]}},
                     x_reg, 15'd0} + prod_reg[apd_pkg::MUL_A_W-1:0];

    // Stored v: vq/2^15 toward zero, clamped
    assign vq_adj   = vq_reg + (vq_reg[apd_pkg::MUL_A_W-1] ? 32'sd32767 : 32'sd0);
    assign vq_shift = vq_adj >>> 15;
    assign v_sat    = sat16(vq_shift[apd_pkg::NARROW_W-1:0]);

    // Output: (d*2^30 - g*vq)/2^30 toward zero, clamped
    assign yq = {{(apd_pkg::YQ_W-apd_pkg::SAMPLE_W-30){d_reg[apd_pkg::SAMPLE_W-1]}},
                 d_reg, 30'd0}
              - {prod_reg[apd_pkg::PROD_W-1], prod_reg};
    assign yq_adj   = yq + (yq[apd_pkg::YQ_W-1] ? {{(apd_pkg::YQ_W-30){1'b0}}, {30{1'b1}}}
                                                 : '0);
    assign yq_shift = yq_adj >>> 30;
    assign y_sat    = sat16(yq_shift[apd_pkg::NARROW_W-1:0]);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg   <= in_ch.sample_in;
            eob_reg <= in_ch.end_of_block;
        end
        if (ctrl.ld_d)
        begin
            d_reg <= d_val;
        end
        if (ctrl.ld_d || ctrl.ld_gv)
        begin
            prod_reg <= mul_p;
        end
        if (ctrl.ld_vq)
        begin
            vq_reg <= vq_sum;
        end
        if (ctrl.ld_out)
        begin
            out_sample_reg <= y_sat;
            out_done_reg   <= eob_reg;
        end
    end

    assign in_ch.ready       = ctrl.in_ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.block_done = out_done_reg;

endmodule

### sv/apd_ram.sv
module apd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/apd_checker.sv
module apd_checker (
    input  logic      clk,
    input  logic      rst_n,
    apd_in_if.sink    in_ch,
    apd_out_if.source out_ch,
    apd_cfg_if.sink   cfg
);

    // A pending result holds its value until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sample_out)
                                          && $stable(out_ch.block_done))
        else $error("result changed while stalled");

    // One sample at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken while a sample is in flight");

    // Every accepted sample is followed by a presented result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |-> ##5 out_ch.valid)
        else $error("result missing after accepted sample");

    // The configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |-> cfg.ready)
        else $error("configuration write stalled");

endmodule

bind allpass_delay_filter apd_checker u_apd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
);
